// ===== src/cle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the console line editor: character codes,
// command kinds passed from the front end to the back end, and widths.
// ----------------------------------------------------------------------------
package cle_pkg;

	// line buffer sizing
	localparam int MAX_LINE    = 64;
	localparam int CAP_TOP     = (MAX_LINE > 64) ? 64 : MAX_LINE;
	localparam int CAP_MIN     = 2;
	localparam int CAP_W       = 7;
	localparam int POS_W       = 6;
	localparam int BYTE_W      = 8;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// output item packing
	localparam int OUT_DATA_W  = 32;

	// character codes
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DEL = 8'h7f;

	// what the back end has to carry out for one input item
	typedef enum logic [2:0] {
		KIND_ERASE,
		KIND_CR,
		KIND_EOL,
		KIND_CHAR,
		KIND_CHAR_FULL
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [BYTE_W-1:0] data;
		logic [POS_W-1:0]  pos;
	} cmd_t;

	// step counter within one command
	typedef logic [1:0] step_t;

endpackage

// ===== src/cle_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_front
// Accepts received bytes, classifies them against the current line position
// and the capacity register, updates the position and issues one command;
// an erase at the start of a line issues none.
module cle_front import cle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              push,
	output cmd_t              push_cmd,
	input  logic              queue_full
);

	logic [CAP_W-1:0] capacity_q;
	logic [POS_W-1:0] pos_q;
	logic [CAP_W-1:0] cap_eff;
	logic [CAP_W-1:0] limit;
	logic [CAP_W-1:0] pos_inc;
	logic             accept;
	logic             is_erase;
	logic             full;
	cmd_kind_t        kind;
	logic [POS_W-1:0] pos_next;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_W'(MAX_LINE > 64 ? 64 : MAX_LINE);
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// clamp capacity and derive the fill limit
	always_comb begin
		cap_eff = capacity_q;
		if (cap_eff > CAP_W'(CAP_TOP)) cap_eff = CAP_W'(CAP_TOP);
		if (cap_eff < CAP_W'(CAP_MIN)) cap_eff = CAP_W'(CAP_MIN);
		limit   = cap_eff - CAP_W'(1);
		pos_inc = {1'b0, pos_q} + CAP_W'(1);
		full    = (pos_inc >= limit);
	end

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign is_erase = (in_byte == CH_DEL) || (in_byte == CH_BS);

	// classify the item and work out the next position
	always_comb begin
		kind     = KIND_CHAR;
		pos_next = pos_q;
		if (is_erase) begin
			kind     = KIND_ERASE;
			pos_next = pos_q - POS_W'(1);
		end else if (in_byte == CH_CR) begin
			kind     = KIND_CR;
			pos_next = '0;
		end else if (in_byte == CH_LF || in_byte == CH_NUL) begin
			kind     = KIND_EOL;
			pos_next = '0;
		end else if (full) begin
			kind     = KIND_CHAR_FULL;
			pos_next = '0;
		end else begin
			kind     = KIND_CHAR;
			pos_next = pos_inc[POS_W-1:0];
		end
	end

	// erase at the start of a line is dropped
	assign push          = accept && !(is_erase && pos_q == '0);
	assign push_cmd.kind = kind;
	assign push_cmd.data = in_byte;
	assign push_cmd.pos  = pos_q;

	// line position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= pos_next;
		end
	end

endmodule

// ===== src/cle_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_queue
// Short command queue that lets the front end and the back end stall
// independently of each other.
// ----------------------------------------------------------------------------
module cle_queue import cle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

// ===== src/cle_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_back
// Expands each command into its one to three result items and holds them
// in an output register towards the receiver.
// ----------------------------------------------------------------------------
module cle_back import cle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  cmd_t                  head_cmd,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_last
);

	step_t             step_q;
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic              out_last_q;
	logic              load;

	logic              echo_valid;
	logic [BYTE_W-1:0] echo_byte;
	logic              store_valid;
	logic [POS_W-1:0]  store_index;
	logic [BYTE_W-1:0] store_byte;
	logic              line_done;
	logic [POS_W-1:0]  line_length;
	logic              is_last;
	logic [POS_W-1:0]  pos_inc;

	assign pos_inc = head_cmd.pos + POS_W'(1);

	// result fields for the current command and step
	always_comb begin
		echo_valid  = 1'b0;
		echo_byte   = '0;
		store_valid = 1'b0;
		store_index = '0;
		store_byte  = '0;
		line_done   = 1'b0;
		line_length = '0;
		is_last     = 1'b1;
		unique case (head_cmd.kind)
			KIND_ERASE: begin
				echo_valid = 1'b1;
				echo_byte  = (step_q == 2'd1) ? CH_SP : CH_BS;
				is_last    = (step_q == 2'd2);
			end
			KIND_CR: begin
				echo_valid = 1'b1;
				if (step_q == 2'd0) begin
					echo_byte = CH_CR;
					is_last   = 1'b0;
				end else begin
					echo_byte   = CH_LF;
					store_valid = 1'b1;
					store_index = head_cmd.pos;
					line_done   = 1'b1;
					line_length = head_cmd.pos;
				end
			end
			KIND_EOL: begin
				echo_valid  = 1'b1;
				echo_byte   = head_cmd.data;
				store_valid = 1'b1;
				store_index = head_cmd.pos;
				line_done   = 1'b1;
				line_length = head_cmd.pos;
			end
			KIND_CHAR: begin
				echo_valid  = 1'b1;
				echo_byte   = head_cmd.data;
				store_valid = 1'b1;
				store_index = head_cmd.pos;
				store_byte  = head_cmd.data;
			end
			KIND_CHAR_FULL: begin
				if (step_q == 2'd0) begin
					echo_valid  = 1'b1;
					echo_byte   = head_cmd.data;
					store_valid = 1'b1;
					store_index = head_cmd.pos;
					store_byte  = head_cmd.data;
					is_last     = 1'b0;
				end else begin
					store_valid = 1'b1;
					store_index = pos_inc;
					line_done   = 1'b1;
					line_length = pos_inc;
				end
			end
			default: begin
				is_last = 1'b1;
			end
		endcase
	end

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && is_last;

	// step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= is_last ? step_t'(0) : step_q + step_t'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= {1'b0, line_length, line_done, store_byte, store_index,
				store_valid, echo_byte, echo_valid};
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

// ===== src/console_line_editor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_editor_core
// Console line discipline with echo: edits one line of received bytes and
// reports echo bytes, buffer stores and line completion.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per item. m_axis carries the results:
//   every byte gives one to three items, the final one marked by tlast;
//   an erase at the start of a line gives none.
//   cfg_we/cfg_wdata write the line capacity; write only while idle.
// Path: a taken byte is queued as a command; the back end registers each result.
// Throughput: the front end takes one byte per cycle while the four-entry
//   command queue has room; the back end sends one item per cycle from its
//   single output register while commands wait and m_axis_tready is high.
// Reset: arst_n clears line position, queue and output valid; capacity
//   returns to 64.
// Stall: if m_axis_tready is low the output item holds, the queue fills
//   and s_axis_tready drops once four commands are waiting.
// ----------------------------------------------------------------------------
module console_line_editor_core import cle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CAP_W-1:0]      cfg_wdata,        // line_capacity
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [BYTE_W-1:0]     s_axis_tdata,     // rx_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// echo_valid, echo_byte, store_valid, store_index, store_byte,
	// line_done, line_length, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast      // last
);

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	// byte classification and line position
	cle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_byte    (s_axis_tdata),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (queue_full)
	);

	// command queue
	cle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// result expansion and output register
	cle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule

// ===== src/cle_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks on the line editor output stream, bound to the top level.
// ----------------------------------------------------------------------------
module cle_checker import cle_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast
);

	// a stalled output item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// an item without echo is only the terminator of a full line
	a_noecho: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |->
			m_axis_tdata[24] && m_axis_tlast && m_axis_tdata[23:16] == 8'h00)
		else $error("item without echo is not a terminator");

	// line end closes the byte, stores the terminator at the line length
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24] |->
			m_axis_tlast && m_axis_tdata[9] && m_axis_tdata[15:10] == m_axis_tdata[30:25])
		else $error("line end item malformed");

	// a stored character is echoed as itself
	a_store: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[23:16] != 8'h00 |->
			m_axis_tdata[0] && m_axis_tdata[8:1] == m_axis_tdata[23:16] && m_axis_tdata[9])
		else $error("stored character not echoed");

endmodule

bind console_line_editor_core cle_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
